@@ hw/rtl/rtl_pkg.sv @@
`timescale 1ns / 1ps
// Package for the RGB to TSL conversion: sizes and the CORDIC angle table.
// Used by rtl_cordic_stage and rgb_to_tsl_conversion; depends on nothing.
package rtl_pkg;
   localparam int PIXEL_BITS_DEF = 8;
   localparam int CORDIC_STEPS = 32;
   localparam int TINT_BITS = 16;
   localparam int SAT_BITS = 17;
   localparam int LIGHT_BITS = 16;

   function automatic logic [31:0] atan_turn(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0: v = 32'd536870912;
         5'd1: v = 32'd316933406;
         5'd2: v = 32'd167458907;
         5'd3: v = 32'd85004756;
         5'd4: v = 32'd42667331;
         5'd5: v = 32'd21354465;
         5'd6: v = 32'd10679838;
         5'd7: v = 32'd5340245;
         5'd8: v = 32'd2670164;
         5'd9: v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         5'd24: v = 32'd41;
         5'd25: v = 32'd20;
         5'd26: v = 32'd10;
         5'd27: v = 32'd5;
         5'd28: v = 32'd3;
         5'd29: v = 32'd1;
         5'd30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction
endpackage

@@ hw/rtl/rtl_cordic_stage.sv @@
`timescale 1ns / 1ps
// One CORDIC vectoring micro-rotation with its pipeline register.
// Depends on rtl_pkg for the angle table.
module rtl_cordic_stage #(
   parameter int XW = 64,
   parameter int STEP = 0
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [XW-1:0] x_in,
   input  logic signed [XW-1:0] y_in,
   input  logic        [31:0]   z_in,
   output logic signed [XW-1:0] x_ff,
   output logic signed [XW-1:0] y_ff,
   output logic        [31:0]   z_ff
);
   import rtl_pkg::*;
   logic signed [XW-1:0] dx, dy;
   logic [31:0] ang;
   always_comb begin
      dx = y_in >>> STEP;
      dy = x_in >>> STEP;
      ang = atan_turn(5'(STEP));
   end
   always_ff @(posedge clock) begin
      if (en) begin
         if (!y_in[XW-1]) begin
            x_ff <= x_in + dx;
            y_ff <= y_in - dy;
            z_ff <= z_in + ang;
         end else begin
            x_ff <= x_in - dx;
            y_ff <= y_in + dy;
            z_ff <= z_in - ang;
         end
      end
   end
endmodule

@@ hw/rtl/rgb_to_tsl_conversion.sv @@
`timescale 1ns / 1ps
// RGB to tint/saturation/lightness converter. One pixel word is accepted every
// clock while the result side does not stall; it passes 35 register stages (input
// sums, squares and start vector, the 32-stage CORDIC that finds the tint angle,
// output rounding) on its way to the result outputs. The saturation square-root
// search (17 bits, one per stage) and the lightness scaling run alongside.
// A stall on the result side freezes the whole pipeline. No reset sweep.
module rgb_to_tsl_conversion #(
   parameter int PIXEL_BITS = rtl_pkg::PIXEL_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [PIXEL_BITS-1:0]            req_red,
   input  logic [PIXEL_BITS-1:0]            req_green,
   input  logic [PIXEL_BITS-1:0]            req_blue,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [rtl_pkg::TINT_BITS-1:0]    rsp_tint,
   output logic [rtl_pkg::SAT_BITS-1:0]     rsp_saturation,
   output logic [rtl_pkg::LIGHT_BITS-1:0]   rsp_lightness
);
   import rtl_pkg::*;

   localparam int SW = PIXEL_BITS + 2;          // sum width
   localparam int AW = PIXEL_BITS + 3;          // signed a, c width
   localparam int XW = AW + 34;                 // CORDIC width
   localparam int QW = 2 * AW + 1;              // a*a + c*c
   localparam int MW = 2 * SW + 3;              // 5*s*s
   localparam int NSTEP = CORDIC_STEPS;
   localparam int DEPTH = NSTEP + 2;
   localparam int NUMW = PIXEL_BITS + 18;       // 256*(299R+587G+114B)+500
   localparam int LW = NUMW - 9;
   localparam int LSH = NUMW + 4;
   localparam int LPW = 2 * NUMW - 5;
   localparam logic [LPW-1:0] LRECIP = LPW'(((64'd1 << LSH) + 64'd124) / 64'd125);
   localparam int NSQ = SAT_BITS;
   localparam int SQW = MW + 38;

   logic en;
   logic [DEPTH:0] vld_ff;
   assign en = !rsp_stall || !rsp_valid;
   assign req_stall = !en;

   // Stage 0: sums and signed chromaticity numerators.
   logic [SW-1:0] s0_ff;
   logic signed [AW-1:0] a0_ff, c0_ff;
   logic [NUMW-1:0] num0_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff <= SW'(req_red) + SW'(req_green) + SW'(req_blue);
         a0_ff <= AW'(3 * req_red) - AW'(req_red) - AW'(req_green) - AW'(req_blue);
         c0_ff <= AW'(3 * req_green) - AW'(req_red) - AW'(req_green) - AW'(req_blue);
         num0_ff <= NUMW'((NUMW'(299) * req_red + NUMW'(587) * req_green
                          + NUMW'(114) * req_blue) * 256 + 500);
      end
   end

   // Stage 1: squares, start vector, lightness division by a constant.
   // Dividing by 1000 is a shift by 3 and then an exact reciprocal multiply for 125.
   logic [QW-1:0] q1_ff;
   logic [MW-1:0] m1_ff;
   logic signed [XW-1:0] x1_ff, y1_ff;
   logic cpos1_ff, czero1_ff, szero1_ff;
   logic [LW-1:0] l1_ff;
   logic [LPW-1:0] lprod;
   assign lprod = LPW'(num0_ff[NUMW-1:3]) * LRECIP;
   always_ff @(posedge clock) begin
      if (en) begin
         q1_ff <= QW'(a0_ff) * QW'(a0_ff) + QW'(c0_ff) * QW'(c0_ff);
         m1_ff <= MW'(s0_ff) * MW'(s0_ff) * MW'(5);
         x1_ff <= (c0_ff[AW-1] ? XW'(-c0_ff) : XW'(c0_ff)) <<< 32;
         y1_ff <= (c0_ff[AW-1] ? -XW'(a0_ff) : XW'(a0_ff)) <<< 32;
         cpos1_ff <= !c0_ff[AW-1];
         czero1_ff <= (c0_ff == '0);
         szero1_ff <= (s0_ff == '0);
         l1_ff <= lprod[LSH +: LW];
      end
   end

   // CORDIC chain plus a parallel saturation square-root search.
   logic signed [XW-1:0] xs [NSTEP+1];
   logic signed [XW-1:0] ys [NSTEP+1];
   logic [31:0] zs [NSTEP+1];
   logic [QW+33:0] rq [NSQ];
   logic [MW-1:0] ms [NSQ];
   logic signed [SQW-1:0] pp [NSQ];
   logic signed [SQW-1:0] qq [NSQ];
   logic [16:0] ns [NSTEP+1];
   logic [NSTEP:0] cp, cz, sz;
   logic [LW-1:0] ls [NSTEP+1];
   assign xs[0] = x1_ff;
   assign ys[0] = y1_ff;
   assign zs[0] = '0;
   assign rq[0] = (QW+34)'(q1_ff) << 34;
   assign ms[0] = m1_ff;
   assign pp[0] = SQW'(m1_ff);
   assign qq[0] = -SQW'(m1_ff);
   assign ns[0] = '0;
   assign cp[0] = cpos1_ff;
   assign cz[0] = czero1_ff;
   assign sz[0] = szero1_ff;
   assign ls[0] = l1_ff;

   for (genvar i = 0; i < NSTEP; i++) begin : g_stage
      rtl_cordic_stage #(.XW(XW), .STEP(i)) u_stage (
         .clock(clock), .en(en),
         .x_in(xs[i]), .y_in(ys[i]), .z_in(zs[i]),
         .x_ff(xs[i+1]), .y_ff(ys[i+1]), .z_ff(zs[i+1])
      );
      logic [16:0] ns_ff;
      logic cp_ff, cz_ff, sz_ff;
      logic [LW-1:0] ls_ff;
      if (i < NSQ) begin : g_sqrt
         // Test the candidate bit: (2n-1)^2 * 5 s^2 <= q * 2^34. The left side is
         // kept up to date by shifts and adds: pp holds (2n-1)^2 M, qq holds (2n-1) M.
         localparam int BIT = NSQ - 1 - i;
         logic [16:0] cand;
         logic signed [SQW-1:0] mx, rx, pc;
         logic take;
         always_comb begin
            cand = ns[i] | (17'd1 << BIT);
            mx = SQW'(ms[i]);
            rx = SQW'(rq[i]);
            pc = pp[i] + (qq[i] <<< (BIT + 2)) + (mx <<< (2 * BIT + 2));
            take = (cand <= 17'd65536) && (pc <= rx);
         end
         always_ff @(posedge clock) begin
            if (en) begin
               ns_ff <= take ? cand : ns[i];
            end
         end
         if (i < NSQ - 1) begin : g_carry
            logic [QW+33:0] rq_ff;
            logic [MW-1:0] ms_ff;
            logic signed [SQW-1:0] pp_ff, qq_ff;
            always_ff @(posedge clock) begin
               if (en) begin
                  rq_ff <= rq[i];
                  ms_ff <= ms[i];
                  pp_ff <= take ? pc : pp[i];
                  qq_ff <= take ? qq[i] + (mx <<< (BIT + 1)) : qq[i];
               end
            end
            assign rq[i+1] = rq_ff;
            assign ms[i+1] = ms_ff;
            assign pp[i+1] = pp_ff;
            assign qq[i+1] = qq_ff;
         end
      end else begin : g_hold
         always_ff @(posedge clock) begin
            if (en) ns_ff <= ns[i];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            cp_ff <= cp[i];
            cz_ff <= cz[i];
            sz_ff <= sz[i];
            ls_ff <= ls[i];
         end
      end
      assign ns[i+1] = ns_ff;
      assign cp[i+1] = cp_ff;
      assign cz[i+1] = cz_ff;
      assign sz[i+1] = sz_ff;
      assign ls[i+1] = ls_ff;
   end

   // Final stage: quadrant offset, rounding and the special cases.
   logic [31:0] t_sum;
   logic [32:0] t_rnd;
   assign t_sum = zs[NSTEP] + (cp[NSTEP] ? 32'h4000_0000 : 32'hC000_0000);
   assign t_rnd = {1'b0, t_sum} + 33'h8000;
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tint <= (sz[NSTEP] || cz[NSTEP]) ? '0 : t_rnd[31:16];
         rsp_saturation <= sz[NSTEP] ? '0 : ns[NSTEP];
         rsp_lightness <= sz[NSTEP] ? '0 :
            ((ls[NSTEP] > LW'(65535)) ? 16'hFFFF : 16'(ls[NSTEP]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[DEPTH-1:0], req_valid};
   end
   assign rsp_valid = vld_ff[DEPTH];

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tint))
      else $error("result changed while stalled");
   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_saturation <= 17'd65536)
      else $error("saturation above one");
   a_in_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without cause");
endmodule
